// ===== rtl/signal_pending_mask_dispatcher_macros.svh =====
// Assertion macros shared by the dispatcher RTL.
`ifndef SIGNAL_PENDING_MASK_DISPATCHER_MACROS_SVH
`define SIGNAL_PENDING_MASK_DISPATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spmd check failed");

// Next-cycle implication, checked outside reset.
`define SPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spmd check failed");

`endif

// ===== rtl/spmd_pkg.sv =====
package spmd_pkg;

	localparam int SIG_W  = 6;
	localparam int WORD_W = 64;

	// Command codes.
	localparam logic [2:0] CMD_SET_ACTION = 3'd0;
	localparam logic [2:0] CMD_SEND       = 3'd1;
	localparam logic [2:0] CMD_MASK_OP    = 3'd2;
	localparam logic [2:0] CMD_DELIVER    = 3'd3;
	localparam logic [2:0] CMD_RETURN     = 3'd4;

	// Mask operation codes.
	localparam logic [1:0] HOW_BLOCK   = 2'd0;
	localparam logic [1:0] HOW_UNBLOCK = 2'd1;
	localparam logic [1:0] HOW_SET     = 2'd2;

	// Delivery actions.
	localparam logic [1:0] ACT_NONE      = 2'd0;
	localparam logic [1:0] ACT_IGNORED   = 2'd1;
	localparam logic [1:0] ACT_TERMINATE = 2'd2;
	localparam logic [1:0] ACT_HANDLER   = 2'd3;

	localparam logic [0:0] ST_OK    = 1'b0;
	localparam logic [0:0] ST_INVAL = 1'b1;

	// Handler values with special meaning.
	localparam logic [WORD_W-1:0] HDL_DEFAULT = 64'd0;
	localparam logic [WORD_W-1:0] HDL_IGNORE  = 64'd1;

	// Signals that cannot be blocked or have their action changed.
	localparam logic [SIG_W-1:0] SIG_KILL = 6'd9;
	localparam logic [SIG_W-1:0] SIG_STOP = 6'd19;

	// Signals whose default action is to ignore them.
	localparam logic [SIG_W-1:0] SIG_DFL_IGN_A = 6'd17;
	localparam logic [SIG_W-1:0] SIG_DFL_IGN_B = 6'd18;
	localparam logic [SIG_W-1:0] SIG_DFL_IGN_C = 6'd23;

	localparam logic [WORD_W-1:0] UNBLOCKABLE = (64'd1 << 9) | (64'd1 << 19);

	localparam logic [7:0]        EXIT_BASE    = 8'd128;
	localparam logic [WORD_W-1:0] TRAMP_OFFSET = 64'd144;
	localparam logic [WORD_W-1:0] ALIGN_MASK   = 64'hF;
	localparam logic [WORD_W-1:0] RET_SLOT     = 64'd8;

	typedef struct packed {
		logic [WORD_W-1:0] handler;
		logic [WORD_W-1:0] flags;
		logic [WORD_W-1:0] mask;
	} action_entry_t;

	typedef struct packed {
		logic          en;
		logic [SIG_W-1:0] addr;
		action_entry_t data;
	} ram_wr_t;

	typedef struct packed {
		logic [0:0]        status;
		logic [WORD_W-1:0] old_handler;
		logic [WORD_W-1:0] old_flags;
		logic [WORD_W-1:0] old_mask;
		logic [1:0]        action;
		logic [SIG_W-1:0]  delivered_signal;
		logic [7:0]        exit_code;
		logic [WORD_W-1:0] handler_entry;
		logic [WORD_W-1:0] new_stack;
		logic [WORD_W-1:0] trampoline_addr;
		logic              wake_request;
	} result_t;

endpackage

// ===== rtl/spmd_action_ram.sv =====
module spmd_action_ram #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [spmd_pkg::SIG_W-1:0]   rd_addr,
	input  spmd_pkg::ram_wr_t            wr,
	output spmd_pkg::action_entry_t      rd_data
);

	localparam int AW = $clog2(DEPTH);

	spmd_pkg::action_entry_t mem [DEPTH];
	spmd_pkg::action_entry_t data_q;
	logic [DEPTH-1:0]        vld_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr[AW-1:0]];
		end
	end

	// An entry never written reads as the reset action: default handler, zero flags and mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr[AW-1:0]];
			end
		end
	end

	assign rd_data = rd_vld_q ? data_q : '0;

endmodule

// ===== rtl/spmd_pick.sv =====
module spmd_pick (
	input  logic [spmd_pkg::WORD_W-1:0] ready_set,
	output logic                        any,
	output logic [spmd_pkg::SIG_W-1:0]  sig
);

	logic [spmd_pkg::WORD_W-1:0] lowest;

	// Isolate the lowest set bit, then encode the one-hot word.
	assign lowest = ready_set & (~ready_set + 64'd1);
	assign any    = |ready_set;

	always_comb begin
		sig = '0;
		for (int i = 0; i < spmd_pkg::WORD_W; i++) begin
			if (lowest[i]) begin
				sig = sig | i[spmd_pkg::SIG_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/signal_pending_mask_dispatcher.sv =====
// A command is registered into the read-modify-write stage on accept, and its result into the
// output register when that stage fires. The action table is read on accept and written back
// as the command leaves; in_ready stays low while a command is in the read-modify-write stage.
// A finished result may wait in the output register while the next command is accepted.
// Reset is asynchronous and active low; it clears the pending and blocked sets, the in-handler
// flag and the table valid bits, so every action reads as default at once (no clearing pass).
`include "signal_pending_mask_dispatcher_macros.svh"

module signal_pending_mask_dispatcher #(
	parameter int NUM_SIGNALS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [5:0]  signal_number,
	input  logic        has_new,
	input  logic [63:0] new_handler,
	input  logic [63:0] new_flags,
	input  logic [63:0] new_mask,
	input  logic [1:0]  mask_how,
	input  logic [63:0] stack_pointer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [63:0] old_handler,
	output logic [63:0] old_flags,
	output logic [63:0] old_mask,
	output logic [1:0]  action,
	output logic [5:0]  delivered_signal,
	output logic [7:0]  exit_code,
	output logic [63:0] handler_entry,
	output logic [63:0] new_stack,
	output logic [63:0] trampoline_addr,
	output logic        wake_request
);

	localparam logic [63:0] SIG_RANGE = (NUM_SIGNALS >= 64) ? '1
		: ((64'd1 << NUM_SIGNALS) - 64'd1);
	localparam logic [63:0] VALID_SIGS = SIG_RANGE & ~64'd1;
	localparam logic [6:0]  NUM_SIGS_W = 7'(NUM_SIGNALS);

	logic [63:0] pending_q;
	logic [63:0] blocked_q;
	logic        in_handler_q;

	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [5:0]  sig_s1;
	logic        has_new_s1;
	logic [63:0] handler_s1;
	logic [63:0] flags_s1;
	logic [63:0] mask_s1;
	logic [1:0]  how_s1;
	logic [63:0] tramp_s1;
	logic        dlv_s1;
	logic [5:0]  pick_s1;

	logic                    out_valid_q;
	spmd_pkg::result_t       out_q;
	spmd_pkg::result_t       res;
	spmd_pkg::action_entry_t rd_data;
	spmd_pkg::ram_wr_t       ram_wr;

	logic        accept;
	logic        fire_s1;
	logic [63:0] ready_set;
	logic        pick_any;
	logic [5:0]  pick_sig;
	logic        do_deliver;
	logic [5:0]  rd_addr;
	logic        set_bad;
	logic        sig_out_of_range;
	logic [63:0] pending_nxt;
	logic [63:0] blocked_nxt;
	logic        in_handler_nxt;

	assign in_ready = !valid_s1;
	assign accept   = in_valid && in_ready;
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);

	assign ready_set = pending_q & ~blocked_q & VALID_SIGS;

	spmd_pick u_pick (
		.ready_set (ready_set),
		.any       (pick_any),
		.sig       (pick_sig)
	);

	// A return clears the in-handler flag first, so it may deliver only from inside a handler.
	assign do_deliver = pick_any
		&& (((cmd == spmd_pkg::CMD_DELIVER) && !in_handler_q)
		 || ((cmd == spmd_pkg::CMD_RETURN) && in_handler_q));

	assign rd_addr = (cmd == spmd_pkg::CMD_SET_ACTION) ? signal_number : pick_sig;

	spmd_action_ram #(
		.DEPTH (NUM_SIGNALS)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (ram_wr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			sig_s1     <= signal_number;
			has_new_s1 <= has_new;
			handler_s1 <= new_handler;
			flags_s1   <= new_flags;
			mask_s1    <= new_mask;
			how_s1     <= mask_how;
			tramp_s1   <= (stack_pointer - spmd_pkg::TRAMP_OFFSET) & ~spmd_pkg::ALIGN_MASK;
			dlv_s1     <= do_deliver;
			pick_s1    <= pick_sig;
		end
	end

	assign sig_out_of_range = {1'b0, sig_s1} >= NUM_SIGS_W;
	assign set_bad = (sig_s1 == '0) || sig_out_of_range
		|| (sig_s1 == spmd_pkg::SIG_KILL) || (sig_s1 == spmd_pkg::SIG_STOP);

	always_comb begin
		res            = '0;
		pending_nxt    = pending_q;
		blocked_nxt    = blocked_q;
		in_handler_nxt = in_handler_q;
		ram_wr         = '0;
		ram_wr.addr    = sig_s1;
		ram_wr.data    = '{handler: handler_s1, flags: flags_s1, mask: mask_s1};
		case (cmd_s1)
			spmd_pkg::CMD_SET_ACTION: begin
				if (set_bad) begin
					res.status = spmd_pkg::ST_INVAL;
				end else begin
					res.old_handler = rd_data.handler;
					res.old_flags   = rd_data.flags;
					res.old_mask    = rd_data.mask;
					ram_wr.en       = fire_s1 && has_new_s1;
				end
			end
			spmd_pkg::CMD_SEND: begin
				if (sig_out_of_range) begin
					res.status = spmd_pkg::ST_INVAL;
				end else if (sig_s1 != '0) begin
					pending_nxt      = pending_q | (64'd1 << sig_s1);
					res.wake_request = 1'b1;
				end
			end
			spmd_pkg::CMD_MASK_OP: begin
				res.old_mask = blocked_q;
				if (has_new_s1) begin
					case (how_s1)
						spmd_pkg::HOW_BLOCK:   blocked_nxt = (blocked_q | mask_s1)
							& ~spmd_pkg::UNBLOCKABLE;
						spmd_pkg::HOW_UNBLOCK: blocked_nxt = (blocked_q & ~mask_s1)
							& ~spmd_pkg::UNBLOCKABLE;
						spmd_pkg::HOW_SET:     blocked_nxt = mask_s1 & ~spmd_pkg::UNBLOCKABLE;
						default:               res.status = spmd_pkg::ST_INVAL;
					endcase
				end
			end
			spmd_pkg::CMD_DELIVER, spmd_pkg::CMD_RETURN: begin
				if ((cmd_s1 == spmd_pkg::CMD_RETURN) && !in_handler_q) begin
					res.status = spmd_pkg::ST_INVAL;
				end else begin
					if (cmd_s1 == spmd_pkg::CMD_RETURN) begin
						in_handler_nxt = 1'b0;
					end
					if (dlv_s1) begin
						pending_nxt          = pending_q & ~(64'd1 << pick_s1);
						res.delivered_signal = pick_s1;
						if (rd_data.handler == spmd_pkg::HDL_DEFAULT) begin
							if ((pick_s1 == spmd_pkg::SIG_DFL_IGN_A)
							 || (pick_s1 == spmd_pkg::SIG_DFL_IGN_B)
							 || (pick_s1 == spmd_pkg::SIG_DFL_IGN_C)) begin
								res.action = spmd_pkg::ACT_IGNORED;
							end else begin
								res.action    = spmd_pkg::ACT_TERMINATE;
								res.exit_code = spmd_pkg::EXIT_BASE + {2'b00, pick_s1};
							end
						end else if (rd_data.handler == spmd_pkg::HDL_IGNORE) begin
							res.action = spmd_pkg::ACT_IGNORED;
						end else begin
							res.action          = spmd_pkg::ACT_HANDLER;
							res.handler_entry   = rd_data.handler;
							res.trampoline_addr = tramp_s1;
							res.new_stack       = tramp_s1 - spmd_pkg::RET_SLOT;
							in_handler_nxt      = 1'b1;
						end
					end
				end
			end
			default: begin
				res.status = spmd_pkg::ST_INVAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			blocked_q    <= '0;
			in_handler_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire_s1) begin
				pending_q    <= pending_nxt;
				blocked_q    <= blocked_nxt;
				in_handler_q <= in_handler_nxt;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status[0];
	assign old_handler      = out_q.old_handler;
	assign old_flags        = out_q.old_flags;
	assign old_mask         = out_q.old_mask;
	assign action           = out_q.action;
	assign delivered_signal = out_q.delivered_signal;
	assign exit_code        = out_q.exit_code;
	assign handler_entry    = out_q.handler_entry;
	assign new_stack        = out_q.new_stack;
	assign trampoline_addr  = out_q.trampoline_addr;
	assign wake_request     = out_q.wake_request;

	`SPMD_ASSERT_NOW(a_never_blocked, clk, arst_n, 1'b1, !blocked_q[9] && !blocked_q[19])
	`SPMD_ASSERT_NOW(a_pick_ready, clk, arst_n, fire_s1 && dlv_s1,
		pending_q[pick_s1] && !blocked_q[pick_s1])
	`SPMD_ASSERT_NEXT(a_pick_cleared, clk, arst_n, fire_s1 && dlv_s1,
		!pending_q[$past(pick_s1)])
	`SPMD_ASSERT_NEXT(a_handler_entered, clk, arst_n,
		fire_s1 && (res.action == spmd_pkg::ACT_HANDLER), in_handler_q)

endmodule

// ===== verif/signal_pending_mask_dispatcher_tb.sv =====
module signal_pending_mask_dispatcher_tb;

	localparam logic [2:0] CMD_BAD_LO = 3'd5;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;
	localparam logic [1:0] HOW_BAD    = 2'd3;
	localparam logic [63:0] ALL_ONES  = '1;
	localparam int RANDOM_CMDS = 2000;
	localparam int HOLD_AFTER  = 300;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic [2:0]  cmd;
		logic [5:0]  sig;
		logic        has_new;
		logic [63:0] hdl;
		logic [63:0] flg;
		logic [63:0] msk;
		logic [1:0]  how;
		logic [63:0] sp;
		int unsigned gap;
		bit          drain;
	} sig_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd = '0;
	logic [5:0]  signal_number = '0;
	logic        has_new = 1'b0;
	logic [63:0] new_handler = '0;
	logic [63:0] new_flags = '0;
	logic [63:0] new_mask = '0;
	logic [1:0]  mask_how = '0;
	logic [63:0] stack_pointer = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        status;
	logic [63:0] old_handler;
	logic [63:0] old_flags;
	logic [63:0] old_mask;
	logic [1:0]  action;
	logic [5:0]  delivered_signal;
	logic [7:0]  exit_code;
	logic [63:0] handler_entry;
	logic [63:0] new_stack;
	logic [63:0] trampoline_addr;
	logic        wake_request;
	spmd_pkg::result_t dut_result;

	sig_cmd_t          cmd_q[$];
	spmd_pkg::result_t outcome_q[$];
	int       err_cnt = 0;
	int       cmds_accepted = 0;
	int       beats_checked = 0;
	logic     long_hold = 1'b0;

	// Predicted controller state.
	logic [63:0] act_handler [64];
	logic [63:0] act_flags [64];
	logic [63:0] act_mask [64];
	logic [63:0] pending_sigs;
	logic [63:0] blocked_sigs;
	logic        in_hdl;

	signal_pending_mask_dispatcher i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.signal_number    (signal_number),
		.has_new          (has_new),
		.new_handler      (new_handler),
		.new_flags        (new_flags),
		.new_mask         (new_mask),
		.mask_how         (mask_how),
		.stack_pointer    (stack_pointer),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.old_handler      (old_handler),
		.old_flags        (old_flags),
		.old_mask         (old_mask),
		.action           (action),
		.delivered_signal (delivered_signal),
		.exit_code        (exit_code),
		.handler_entry    (handler_entry),
		.new_stack        (new_stack),
		.trampoline_addr  (trampoline_addr),
		.wake_request     (wake_request)
	);

	assign dut_result = {status, old_handler, old_flags, old_mask, action, delivered_signal,
		exit_code, handler_entry, new_stack, trampoline_addr, wake_request};

	always #4 clk = ~clk;

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Picks the lowest pending unblocked signal and works out what happens to it.
	function automatic void run_delivery(input logic [63:0] sp, inout spmd_pkg::result_t r);
		logic [63:0] ready_set;
		logic [5:0]  s;
		logic [63:0] h;
		logic [63:0] tramp;
		ready_set = pending_sigs & ~blocked_sigs & ~64'd1;
		if (in_hdl || ready_set == '0)
			return;
		s = 6'd1;
		while (s < 6'd63 && !ready_set[s])
			s++;
		pending_sigs[s] = 1'b0;
		r.delivered_signal = s;
		h = act_handler[s];
		if (h == spmd_pkg::HDL_DEFAULT) begin
			if (s == spmd_pkg::SIG_DFL_IGN_A || s == spmd_pkg::SIG_DFL_IGN_B
			 || s == spmd_pkg::SIG_DFL_IGN_C) begin
				r.action = spmd_pkg::ACT_IGNORED;
			end else begin
				r.action = spmd_pkg::ACT_TERMINATE;
				r.exit_code = spmd_pkg::EXIT_BASE + {2'b00, s};
			end
		end else if (h == spmd_pkg::HDL_IGNORE) begin
			r.action = spmd_pkg::ACT_IGNORED;
		end else begin
			tramp = (sp - spmd_pkg::TRAMP_OFFSET) & ~spmd_pkg::ALIGN_MASK;
			r.action = spmd_pkg::ACT_HANDLER;
			r.handler_entry = h;
			r.trampoline_addr = tramp;
			r.new_stack = tramp - spmd_pkg::RET_SLOT;
			in_hdl = 1'b1;
		end
	endfunction

	function automatic void predict_outcome(input sig_cmd_t c);
		spmd_pkg::result_t r;
		r = '0;
		case (c.cmd)
			spmd_pkg::CMD_SET_ACTION: begin
				if (c.sig == 6'd0 || c.sig == spmd_pkg::SIG_KILL
				 || c.sig == spmd_pkg::SIG_STOP) begin
					r.status = spmd_pkg::ST_INVAL;
				end else begin
					r.old_handler = act_handler[c.sig];
					r.old_flags = act_flags[c.sig];
					r.old_mask = act_mask[c.sig];
					if (c.has_new) begin
						act_handler[c.sig] = c.hdl;
						act_flags[c.sig] = c.flg;
						act_mask[c.sig] = c.msk;
					end
				end
			end
			spmd_pkg::CMD_SEND: begin
				// Signal zero only probes the context.
				if (c.sig != 6'd0) begin
					pending_sigs[c.sig] = 1'b1;
					r.wake_request = 1'b1;
				end
			end
			spmd_pkg::CMD_MASK_OP: begin
				r.old_mask = blocked_sigs;
				if (c.has_new) begin
					case (c.how)
						spmd_pkg::HOW_BLOCK:
							blocked_sigs = (blocked_sigs | c.msk) & ~spmd_pkg::UNBLOCKABLE;
						spmd_pkg::HOW_UNBLOCK:
							blocked_sigs = (blocked_sigs & ~c.msk) & ~spmd_pkg::UNBLOCKABLE;
						spmd_pkg::HOW_SET:
							blocked_sigs = c.msk & ~spmd_pkg::UNBLOCKABLE;
						default:
							r.status = spmd_pkg::ST_INVAL;
					endcase
				end
			end
			spmd_pkg::CMD_DELIVER: run_delivery(c.sp, r);
			spmd_pkg::CMD_RETURN: begin
				if (!in_hdl) begin
					r.status = spmd_pkg::ST_INVAL;
				end else begin
					in_hdl = 1'b0;
					run_delivery(c.sp, r);
				end
			end
			default: r.status = spmd_pkg::ST_INVAL;
		endcase
		outcome_q.push_back(r);
	endfunction

	task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	task automatic check_outcome(input spmd_pkg::result_t got);
		spmd_pkg::result_t want;
		if (outcome_q.size() == 0) begin
			$error("result beat arrived with no command outstanding");
			err_cnt++;
			return;
		end
		want = outcome_q.pop_front();
		cmp_field("status", 64'(want.status), 64'(got.status));
		cmp_field("old_handler", want.old_handler, got.old_handler);
		cmp_field("old_flags", want.old_flags, got.old_flags);
		cmp_field("old_mask", want.old_mask, got.old_mask);
		cmp_field("action", 64'(want.action), 64'(got.action));
		cmp_field("delivered_signal", 64'(want.delivered_signal), 64'(got.delivered_signal));
		cmp_field("exit_code", 64'(want.exit_code), 64'(got.exit_code));
		cmp_field("handler_entry", want.handler_entry, got.handler_entry);
		cmp_field("new_stack", want.new_stack, got.new_stack);
		cmp_field("trampoline_addr", want.trampoline_addr, got.trampoline_addr);
		cmp_field("wake_request", 64'(want.wake_request), 64'(got.wake_request));
	endtask

	task automatic add_cmd(input logic [2:0] c, input logic [5:0] s, input logic hn,
			input logic [63:0] h, input logic [63:0] f, input logic [63:0] m,
			input logic [1:0] hw, input logic [63:0] sp);
		sig_cmd_t it;
		it.cmd = c;
		it.sig = s;
		it.has_new = hn;
		it.hdl = h;
		it.flg = f;
		it.msk = m;
		it.how = hw;
		it.sp = sp;
		// Every third stretch of commands is sent back to back.
		it.gap = ((cmd_q.size() / 128) % 3 == 0) ? 0 : $urandom_range(0, 14);
		it.drain = 1'b0;
		cmd_q.push_back(it);
	endtask

	task automatic add_random_cmd();
		int unsigned pick;
		logic [5:0]  s;
		logic [63:0] h;
		logic [63:0] m;
		logic [63:0] sp;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: s = spmd_pkg::SIG_KILL;
			1: s = spmd_pkg::SIG_STOP;
			2: s = spmd_pkg::SIG_DFL_IGN_A + 6'($urandom_range(0, 1));
			3: s = spmd_pkg::SIG_DFL_IGN_C;
			4: s = 6'd0;
			default: s = 6'($urandom_range(1, 63));
		endcase
		case ($urandom_range(0, 3))
			0: h = spmd_pkg::HDL_DEFAULT;
			1: h = spmd_pkg::HDL_IGNORE;
			default: h = rand_word();
		endcase
		m = $urandom_range(0, 1) ? rand_word() : (64'd1 << $urandom_range(0, 63));
		sp = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 200)) : rand_word();
		if (pick < 15)
			add_cmd(spmd_pkg::CMD_SET_ACTION, s, $urandom_range(0, 3) != 0, h, rand_word(),
				rand_word(), 2'($urandom_range(0, 3)), sp);
		else if (pick < 45)
			add_cmd(spmd_pkg::CMD_SEND, s, 1'($urandom), rand_word(), rand_word(), m,
				2'($urandom_range(0, 3)), sp);
		else if (pick < 60)
			add_cmd(spmd_pkg::CMD_MASK_OP, s, $urandom_range(0, 5) != 0, rand_word(),
				rand_word(), m, 2'($urandom_range(0, 3)), sp);
		else if (pick < 85)
			add_cmd(spmd_pkg::CMD_DELIVER, s, 1'($urandom), rand_word(), rand_word(), m,
				2'($urandom_range(0, 3)), sp);
		else if (pick < 97)
			add_cmd(spmd_pkg::CMD_RETURN, s, 1'($urandom), rand_word(), rand_word(), m,
				2'($urandom_range(0, 3)), sp);
		else
			add_cmd(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)), s, 1'($urandom), rand_word(),
				rand_word(), m, 2'($urandom_range(0, 3)), sp);
	endtask

	// Driver: takes commands from the queue, idles for each one's gap, holds valid until accepted.
	sig_cmd_t    cur_cmd;
	bit          cmd_staged;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd_staged = 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_outcome(cur_cmd);
				cmds_accepted++;
				cmd_staged = 1'b0;
			end
			// A draining command is held back until every outstanding result has come.
			if (!cmd_staged && cmd_q.size() > 0
			 && (!cmd_q[0].drain || outcome_q.size() == 0)) begin
				cur_cmd = cmd_q.pop_front();
				gap_left = cur_cmd.gap;
				cmd_staged = 1'b1;
			end
			if (cmd_staged && gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cmd_staged) begin
				in_valid <= 1'b1;
				cmd <= cur_cmd.cmd;
				signal_number <= cur_cmd.sig;
				has_new <= cur_cmd.has_new;
				new_handler <= cur_cmd.hdl;
				new_flags <= cur_cmd.flg;
				new_mask <= cur_cmd.msk;
				mask_how <= cur_cmd.how;
				stack_pointer <= cur_cmd.sp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// One long back-pressure stretch on the result side while commands keep coming.
	int  hold_cnt;
	bit  hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_cnt = 0;
			hold_done = 1'b0;
		end else if (!hold_done && cmds_accepted >= HOLD_AFTER) begin
			if (hold_cnt == HOLD_CYCLES) begin
				long_hold <= 1'b0;
				hold_done = 1'b1;
			end else begin
				long_hold <= 1'b1;
				hold_cnt++;
			end
		end
	end

	// Monitor: checks each result beat and stalls at random between beats.
	int unsigned stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_outcome(dut_result);
				beats_checked++;
				stall_left = ((beats_checked / 150) % 3 == 0) ? 0 : $urandom_range(0, 14);
			end
			if (long_hold) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0] hdl_a;
		for (int i = 0; i < 64; i++) begin
			act_handler[i] = spmd_pkg::HDL_DEFAULT;
			act_flags[i] = '0;
			act_mask[i] = '0;
		end
		pending_sigs = '0;
		blocked_sigs = '0;
		in_hdl = 1'b0;

		hdl_a = rand_word() | 64'h2;
		add_cmd(spmd_pkg::CMD_SET_ACTION, 6'd0, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES,
			spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SET_ACTION, spmd_pkg::SIG_KILL, 1'b1, ALL_ONES, ALL_ONES,
			ALL_ONES, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SET_ACTION, spmd_pkg::SIG_STOP, 1'b1, ALL_ONES, ALL_ONES,
			ALL_ONES, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SET_ACTION, 6'd63, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES,
			spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SET_ACTION, 6'd63, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SEND, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SEND, 6'd63, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_MASK_OP, 6'd0, 1'b1, '0, '0, ALL_ONES, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_MASK_OP, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_SET, '0);
		add_cmd(spmd_pkg::CMD_MASK_OP, 6'd0, 1'b1, '0, '0, '0, HOW_BAD, '0);
		add_cmd(spmd_pkg::CMD_SEND, spmd_pkg::SIG_KILL, 1'b0, '0, '0, '0,
			spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SEND, spmd_pkg::SIG_STOP, 1'b0, '0, '0, '0,
			spmd_pkg::HOW_BLOCK, '0);
		// Kill and stop get through a full blocked mask; 63 stays pending behind it.
		add_cmd(spmd_pkg::CMD_DELIVER, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(spmd_pkg::CMD_DELIVER, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(spmd_pkg::CMD_DELIVER, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(spmd_pkg::CMD_MASK_OP, 6'd0, 1'b1, '0, '0, ALL_ONES,
			spmd_pkg::HOW_UNBLOCK, '0);
		add_cmd(spmd_pkg::CMD_SEND, spmd_pkg::SIG_DFL_IGN_A, 1'b0, '0, '0, '0,
			spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SEND, spmd_pkg::SIG_DFL_IGN_C, 1'b0, '0, '0, '0,
			spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SET_ACTION, 6'd5, 1'b1, hdl_a, rand_word(), rand_word(),
			spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_SEND, 6'd5, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, '0);
		// Handler entry with a stack pointer that wraps below zero.
		add_cmd(spmd_pkg::CMD_DELIVER, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(spmd_pkg::CMD_DELIVER, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(spmd_pkg::CMD_RETURN, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, ALL_ONES);
		add_cmd(spmd_pkg::CMD_RETURN, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(spmd_pkg::CMD_RETURN, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(spmd_pkg::CMD_RETURN, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(spmd_pkg::CMD_RETURN, 6'd0, 1'b0, '0, '0, '0, spmd_pkg::HOW_BLOCK, rand_word());
		add_cmd(CMD_BAD_LO, 6'd0, 1'b1, '0, '0, '0, spmd_pkg::HOW_BLOCK, '0);
		add_cmd(CMD_BAD_HI, 6'd63, 1'b1, '0, '0, '0, HOW_BAD, '0);

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			add_random_cmd();
			if (i == RANDOM_CMDS / 2)
				cmd_q[$].drain = 1'b1;
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(posedge clk); while (cmd_q.size() != 0 || cmd_staged);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("signal_pending_mask_dispatcher test passed");
		else
			$display("signal_pending_mask_dispatcher test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("signal_pending_mask_dispatcher test failed");
		$finish;
	end

endmodule
